[hw/rtl/spng_pkg.sv]
// types, commands and constants shared by the shortest-path engine
package spng_pkg;

  localparam int NODES_DEF     = 16;
  localparam int COST_BITS_DEF = 16;
  localparam int MAX_PATH      = 16;

  typedef enum logic [1:0] {
    CMD_RESET = 2'd0,
    CMD_SET   = 2'd1,
    CMD_BLOCK = 2'd2,
    CMD_FIND  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BLOCK2,
    ST_ROUND,
    ST_SCAN,
    ST_TRACE,
    ST_EMIT,
    ST_NOTFOUND
  } state_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  node_a;
    logic [3:0]  node_b;
    logic [15:0] edge_cost;
    logic [15:0] hold_ms;
    logic [31:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic [3:0] path_node;
    logic [3:0] path_index;
    logic       found;
    logic       last;
  } out_word_t;

endpackage

[hw/rtl/spng_edge_mem.sv]
// edge cost and blocked-until memories, one write and one registered read port each
module spng_edge_mem #(
  parameter int NODES     = spng_pkg::NODES_DEF,
  parameter int COST_BITS = spng_pkg::COST_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             cost_we,
  input  logic                             blk_we,
  input  logic [$clog2(NODES*NODES)-1:0]   waddr,
  input  logic [COST_BITS-1:0]             cost_wdata,
  input  logic [31:0]                      blk_wdata,
  input  logic [$clog2(NODES*NODES)-1:0]   raddr,
  output logic [COST_BITS-1:0]             cost_rdata,
  output logic [31:0]                      blk_rdata
);
  import spng_pkg::*;

  localparam int CELLS = NODES * NODES;

  logic [COST_BITS-1:0] cost_mem [CELLS];
  logic [31:0]          blk_mem  [CELLS];

  always_ff @(posedge clk) begin
    if (cost_we) begin
      cost_mem[waddr] <= cost_wdata;
    end
    cost_rdata <= cost_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (blk_we) begin
      blk_mem[waddr] <= blk_wdata;
    end
    blk_rdata <= blk_mem[raddr];
  end

endmodule

[hw/rtl/shortest_path_node_graph.sv]
// Shortest-path engine over a directed graph of NODES nodes. Edge costs and blocked-until
// times live in two NODES*NODES memories. After reset, and on every map-reset command, a
// clearing pass writes all NODES*NODES cells, one cell a cycle, while in_stall stays high.
// Set-cost writes one cell; block writes the two cells (a,b) and (b,a). A path search runs
// minimum-selection Dijkstra: each round settles one node and scans its matrix row through
// the memory read port; once the goal is settled, the path is traced back from the goal
// through the predecessor records and handed out as one output word per path node.
module shortest_path_node_graph #(
  parameter int NODES     = spng_pkg::NODES_DEF,
  parameter int COST_BITS = spng_pkg::COST_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  spng_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output spng_pkg::out_word_t out_data
);
  import spng_pkg::*;

  localparam int NW = $clog2(NODES);
  localparam int AW = $clog2(NODES * NODES);
  localparam int PW = COST_BITS + NW;
  localparam int VW = NW + 1;
  localparam logic [COST_BITS-1:0] NO_EDGE   = {COST_BITS{1'b1}};
  localparam logic [32:0]          NO_EDGE_W = 33'(NO_EDGE);
  localparam logic [NW-1:0]        LAST_NODE = NW'(NODES - 1);
  localparam logic [4:0]           PATH_MAX  = 5'(MAX_PATH);

  state_t state_r, state_nxt;

  logic [NW-1:0]  rc_r, rc_nxt, cc_r, cc_nxt;
  logic [NW-1:0]  s_r, s_nxt, g_r, g_nxt, u_r, u_nxt, n_r, n_nxt;
  logic [31:0]    now_r, now_nxt, until_r, until_nxt;
  logic [AW-1:0]  addr2_r, addr2_nxt;
  logic [PW-1:0]  bu_r, bu_nxt;
  logic [VW-1:0]  v_r, v_nxt;
  logic           pv_r, pv_nxt;
  logic [NW-1:0]  pidx_r, pidx_nxt;
  logic           mf_r, mf_nxt;
  logic [NW-1:0]  midx_r, midx_nxt;
  logic [PW-1:0]  mval_r, mval_nxt;
  logic [NODES-1:0] reached_r, reached_nxt, settled_r, settled_nxt;
  logic [4:0]     cnt_r, cnt_nxt, ei_r, ei_nxt;
  logic           out_valid_r, out_valid_nxt;
  out_word_t      out_r, out_nxt;

  logic [PW-1:0]  best_r [NODES];
  logic [NW-1:0]  from_r [NODES];
  logic [3:0]     path_r [MAX_PATH];

  logic                 cost_we, blk_we;
  logic [AW-1:0]        waddr, raddr;
  logic [COST_BITS-1:0] cost_wdata, cost_rdata;
  logic [31:0]          blk_wdata, blk_rdata;

  logic           accept, slot_free;
  logic           a_ok, b_ok;
  logic [NW-1:0]  a_idx, b_idx;
  logic [32:0]    until_sum;
  logic [31:0]    until_sat;
  logic [COST_BITS-1:0] cost_clamp;
  logic           usable, take, better, scan_end, trace_go;
  logic [PW-1:0]  cand, newbest;
  logic           newreach;
  logic [4:0]     rev;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign slot_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign a_ok  = 32'(in_data.node_a) < NODES;
  assign b_ok  = 32'(in_data.node_b) < NODES;
  assign a_idx = NW'(in_data.node_a);
  assign b_idx = NW'(in_data.node_b);

  assign until_sum  = 33'(in_data.now_ms) + 33'(in_data.hold_ms);
  assign until_sat  = until_sum[32] ? 32'hFFFF_FFFF : until_sum[31:0];
  assign cost_clamp = (in_data.edge_cost == 16'hFFFF || 33'(in_data.edge_cost) > NO_EDGE_W)
                      ? NO_EDGE : COST_BITS'(in_data.edge_cost);

  // row scan datapath
  assign usable   = (cost_rdata != NO_EDGE) && (now_r > blk_rdata);
  assign cand     = bu_r + PW'(cost_rdata);
  assign take     = pv_r && !settled_r[pidx_r] && usable &&
                    (!reached_r[pidx_r] || cand < best_r[pidx_r]);
  assign newbest  = take ? cand : best_r[pidx_r];
  assign newreach = reached_r[pidx_r] || take;
  assign better   = pv_r && newreach && !settled_r[pidx_r] && (!mf_r || newbest < mval_r);
  assign scan_end = pv_r && (pidx_r == LAST_NODE);
  assign trace_go = (n_r != s_r) && (cnt_r != PATH_MAX);
  assign rev      = cnt_r - 5'd1 - ei_r;

  assign raddr = AW'(u_r) * AW'(NODES) + AW'(v_r[NW-1:0]);

  spng_edge_mem #(
    .NODES     (NODES),
    .COST_BITS (COST_BITS)
  ) u_mem (
    .clk        (clk),
    .cost_we    (cost_we),
    .blk_we     (blk_we),
    .waddr      (waddr),
    .cost_wdata (cost_wdata),
    .blk_wdata  (blk_wdata),
    .raddr      (raddr),
    .cost_rdata (cost_rdata),
    .blk_rdata  (blk_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (rc_r == LAST_NODE && cc_r == LAST_NODE) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_t'(in_data.cmd))
            CMD_RESET: state_nxt = ST_CLEAR;
            CMD_SET:   state_nxt = ST_IDLE;
            CMD_BLOCK: state_nxt = (a_ok && b_ok) ? ST_BLOCK2 : ST_IDLE;
            CMD_FIND:  state_nxt = (a_ok && b_ok && a_idx != b_idx) ? ST_ROUND : ST_NOTFOUND;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_BLOCK2: state_nxt = ST_IDLE;
      ST_ROUND:  state_nxt = (u_r == g_r) ? ST_TRACE : ST_SCAN;
      ST_SCAN: begin
        if (scan_end) begin
          if (mf_nxt)                state_nxt = ST_ROUND;
          else if (reached_nxt[g_r]) state_nxt = ST_TRACE;
          else                       state_nxt = ST_NOTFOUND;
        end
      end
      ST_TRACE: begin
        if (n_r == s_r)             state_nxt = ST_EMIT;
        else if (cnt_r == PATH_MAX) state_nxt = ST_NOTFOUND;
      end
      ST_EMIT: begin
        if (slot_free && ei_r == cnt_r - 5'd1) state_nxt = ST_IDLE;
      end
      ST_NOTFOUND: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    rc_nxt = rc_r;  cc_nxt = cc_r;
    s_nxt = s_r;  g_nxt = g_r;  u_nxt = u_r;  n_nxt = n_r;
    now_nxt = now_r;  until_nxt = until_r;  addr2_nxt = addr2_r;
    bu_nxt = bu_r;  v_nxt = v_r;  pv_nxt = 1'b0;  pidx_nxt = v_r[NW-1:0];
    mf_nxt = mf_r;  midx_nxt = midx_r;  mval_nxt = mval_r;
    reached_nxt = reached_r;  settled_nxt = settled_r;
    cnt_nxt = cnt_r;  ei_nxt = ei_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt = out_r;
    cost_we = 1'b0;  blk_we = 1'b0;
    waddr = AW'(rc_r) * AW'(NODES) + AW'(cc_r);
    cost_wdata = (rc_r == cc_r) ? '0 : NO_EDGE;
    blk_wdata = '0;

    unique case (state_r)
      ST_CLEAR: begin
        cost_we = 1'b1;
        blk_we  = 1'b1;
        cc_nxt  = (cc_r == LAST_NODE) ? '0 : cc_r + 1'b1;
        if (cc_r == LAST_NODE) rc_nxt = (rc_r == LAST_NODE) ? '0 : rc_r + 1'b1;
      end
      ST_IDLE: begin
        waddr      = AW'(a_idx) * AW'(NODES) + AW'(b_idx);
        cost_wdata = cost_clamp;
        blk_wdata  = until_sat;
        addr2_nxt  = AW'(b_idx) * AW'(NODES) + AW'(a_idx);
        until_nxt  = until_sat;
        s_nxt      = a_idx;
        g_nxt      = b_idx;
        u_nxt      = a_idx;
        now_nxt    = in_data.now_ms;
        bu_nxt     = '0;
        rc_nxt     = '0;
        cc_nxt     = '0;
        if (accept) begin
          unique case (cmd_t'(in_data.cmd))
            CMD_SET:   cost_we = a_ok && b_ok;
            CMD_BLOCK: blk_we  = a_ok && b_ok;
            CMD_FIND: begin
              reached_nxt        = '0;
              reached_nxt[a_idx] = 1'b1;
              settled_nxt        = '0;
            end
            default: ;
          endcase
        end
      end
      ST_BLOCK2: begin
        waddr     = addr2_r;
        blk_wdata = until_r;
        blk_we    = 1'b1;
      end
      ST_ROUND: begin
        settled_nxt[u_r] = 1'b1;
        v_nxt  = '0;
        mf_nxt = 1'b0;
        n_nxt  = g_r;
        cnt_nxt = 5'd1;
      end
      ST_SCAN: begin
        if (32'(v_r) < NODES) begin
          pv_nxt = 1'b1;
          v_nxt  = v_r + 1'b1;
        end
        if (take) reached_nxt[pidx_r] = 1'b1;
        if (better) begin
          mf_nxt   = 1'b1;
          midx_nxt = pidx_r;
          mval_nxt = newbest;
        end
        if (scan_end) begin
          u_nxt  = midx_nxt;
          bu_nxt = mval_nxt;
        end
        n_nxt   = g_r;
        cnt_nxt = 5'd1;
      end
      ST_TRACE: begin
        ei_nxt = '0;
        if (trace_go) begin
          n_nxt   = from_r[n_r];
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt      = 1'b1;
          out_nxt.path_node  = path_r[rev[3:0]];
          out_nxt.path_index = ei_r[3:0];
          out_nxt.found      = 1'b1;
          out_nxt.last       = (ei_r == cnt_r - 5'd1);
          ei_nxt             = ei_r + 5'd1;
        end
      end
      ST_NOTFOUND: begin
        if (slot_free) begin
          out_valid_nxt      = 1'b1;
          out_nxt.path_node  = '0;
          out_nxt.path_index = '0;
          out_nxt.found      = 1'b0;
          out_nxt.last       = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      rc_r        <= '0;
      cc_r        <= '0;
      pv_r        <= 1'b0;
      mf_r        <= 1'b0;
      reached_r   <= '0;
      settled_r   <= '0;
      out_valid_r <= 1'b0;
      v_r         <= '0;
      cnt_r       <= '0;
      ei_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      rc_r        <= rc_nxt;
      cc_r        <= cc_nxt;
      pv_r        <= pv_nxt;
      mf_r        <= mf_nxt;
      reached_r   <= reached_nxt;
      settled_r   <= settled_nxt;
      out_valid_r <= out_valid_nxt;
      v_r         <= v_nxt;
      cnt_r       <= cnt_nxt;
      ei_r        <= ei_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r     <= s_nxt;
    g_r     <= g_nxt;
    u_r     <= u_nxt;
    n_r     <= n_nxt;
    now_r   <= now_nxt;
    until_r <= until_nxt;
    addr2_r <= addr2_nxt;
    bu_r    <= bu_nxt;
    pidx_r  <= pidx_nxt;
    midx_r  <= midx_nxt;
    mval_r  <= mval_nxt;
    out_r   <= out_nxt;
  end

  // per-node search records and path buffer
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && accept) begin
      best_r[a_idx] <= '0;
      from_r[a_idx] <= a_idx;
    end
    if (state_r == ST_SCAN && take) begin
      best_r[pidx_r] <= cand;
      from_r[pidx_r] <= u_r;
    end
    if (state_r == ST_ROUND || state_r == ST_SCAN) begin
      path_r[0] <= 4'(g_r);
    end
    if (state_r == ST_TRACE && trace_go) begin
      path_r[cnt_r[3:0]] <= 4'(from_r[n_r]);
    end
  end

  a_scan_row_settled: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> settled_r[u_r] && reached_r[u_r])
    else $error("scanning row of a node that is not settled");

  a_emit_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> cnt_r >= 5'd2 && cnt_r <= PATH_MAX)
    else $error("path length out of range while emitting");

  a_notfound_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.found || out_r.last)
    else $error("not-found word without last");

  a_settled_reached: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> (settled_r & ~reached_r) == '0)
    else $error("settled node never reached");

endmodule
